// ===== rtl/deadline_task_scheduler_core_macros.svh =====
// assertion macros for the deadline task scheduler
// used by the top level and the cell module
`ifndef DEADLINE_TASK_SCHEDULER_CORE_MACROS_SVH
`define DEADLINE_TASK_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DTS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DTS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTS_ASSERT(label, clk, rstn, prop, msg)
`define DTS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/dts_pkg.sv =====
// shared types and codes for the deadline task scheduler
// no dependencies
`timescale 1ns / 1ps
package dts_pkg;
    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_FIRED    = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] due;
        logic [31:0] interval;
        logic        rep;
    } slot_t;
endpackage

// ===== rtl/deadline_task_scheduler_core.sv =====
// top level of the deadline task scheduler: control sequencer, slot chain, divider
// depends on dts_pkg, dts_cell, dts_div and the macros header
//
// usage: s_ beats carry an add or a tick, kind on s_tuser; m_ beats carry
// results, m_tlast on the final result of an input beat. s_tdata =
// {repeat_req, delay_ms, task_id, time_ms} with time_ms at bit 0. one input beat is
// taken at a time, only while the output register is free or draining.
// an add's result is registered and valid the cycle after the add is taken.
// a tick walks the slot chain once, head first: each stored task takes a
// walk step and an emit step, and a late repeating task also waits in
// between on the one-bit-per-cycle divider; at the end the final beat is
// loaded and the core returns to idle before the next input beat is
// taken. results go out in table order.
// a stalled receiver holds the output register; the walk pauses while a
// fired result waits to move into a full output register, and no input beat
// is taken until the output register frees.
// reset empties the table and clears the missed count; slot contents are
// not cleared.
`timescale 1ns / 1ps
`include "deadline_task_scheduler_core_macros.svh"
module deadline_task_scheduler_core
    import dts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // time_ms, task_id, delay_ms, repeat_req, zero pad
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status, fired_id, missed_runs, zero pad
    output logic        m_tlast
);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_EMIT} state_t;
    state_t state_reg;

    logic [31:0]   now_reg;
    logic [CW-1:0] count_reg, step_reg, len_reg;
    logic [RW-1:0] nres_reg;
    logic [31:0]   missed_reg;
    logic [1:0]    o_status_reg;
    logic [7:0]    o_id_reg;
    logic          o_last_reg;
    logic [31:0]   o_missed_reg;
    logic          o_valid_reg;
    logic          pend_valid_reg;
    logic [7:0]    pend_id_reg;
    logic [31:0]   pend_missed_reg;

    slot_t chain [MAX_TASKS+1];
    slot_t cell_in [MAX_TASKS];
    logic [MAX_TASKS-1:0] cell_en;
    slot_t head, ins;
    logic  shift_en, ins_en;
    logic [CW-1:0] bnd;

    logic [31:0] t_now, t_delay;
    logic [7:0]  t_id;
    logic        t_rep;
    assign t_now   = s_tdata[31:0];
    assign t_id    = s_tdata[39:32];
    assign t_delay = s_tdata[71:40];
    assign t_rep   = s_tdata[72];

    logic div_start, div_busy;
    logic [31:0] div_q;

    // chain: chain[MAX_TASKS] is the head; live slots sit at the head side
    assign head     = chain[MAX_TASKS];
    assign chain[0] = ins;
    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            assign cell_in[g] = (ins_en && (CW'(g) == bnd)) ? ins : chain[g];
            assign cell_en[g] = shift_en || (ins_en && (CW'(g) == bnd));
            dts_cell u_cell (
                .aclk    (aclk),
                .shift_en(cell_en[g]),
                .slot_in (cell_in[g]),
                .slot_out(chain[g+1])
            );
        end
    endgenerate

    dts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(now_reg - head.due),
        .divisor (head.interval),
        .busy    (div_busy),
        .quotient(div_q)
    );

    logic [31:0] late_due;
    logic due_now, late, out_free, walk_done, report, out_load;
    assign late_due  = head.due + head.interval;
    assign due_now   = (now_reg >= head.due);
    assign late      = head.rep && (head.interval != 32'd0) && (now_reg > late_due);
    assign out_free  = !o_valid_reg || m_tready;
    assign walk_done = (step_reg == count_reg);
    assign report    = due_now && (nres_reg < RW'(MAX_RESULTS));

    // shift combinational control
    logic add_go, walk_step, walk_keep;
    assign add_go    = (state_reg == S_IDLE) && s_tvalid && out_free && !s_tuser
                       && (count_reg < CW'(MAX_TASKS));
    assign walk_step = (state_reg == S_EMIT) && (!pend_valid_reg || out_free);
    assign walk_keep = !due_now || head.rep;

    always_comb begin
        shift_en = 1'b0;
        ins_en   = 1'b0;
        ins      = head;
        bnd      = CW'(MAX_TASKS) - len_reg;
        if (add_go) begin
            // append behind the last live slot
            ins_en = 1'b1;
            ins    = '{t_id, t_now + t_delay, t_delay, t_rep};
            bnd    = CW'(MAX_TASKS - 1) - count_reg;
        end else if (walk_step) begin
            // kept slots go back in at the ring tail, dropped ones leave
            shift_en = 1'b1;
            ins_en   = walk_keep;
            if (due_now && head.rep) ins.due = now_reg + head.interval;
        end
    end

    assign div_start = (state_reg == S_WALK) && !walk_done && due_now && late;
    assign out_load  = ((state_reg == S_IDLE) && s_tvalid && out_free && !s_tuser)
                       || ((state_reg == S_WALK) && walk_done && out_free)
                       || (walk_step && report && pend_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            missed_reg     <= '0;
            o_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && out_free) begin
                        if (!s_tuser) begin
                            o_id_reg     <= t_id;
                            o_last_reg   <= 1'b1;
                            o_missed_reg <= missed_reg;
                            if (count_reg < CW'(MAX_TASKS)) begin
                                o_status_reg <= ST_ADDED;
                                count_reg    <= count_reg + CW'(1);
                            end else begin
                                o_status_reg <= ST_REJECTED;
                            end
                        end else begin
                            now_reg   <= t_now;
                            step_reg  <= '0;
                            len_reg   <= count_reg;
                            nres_reg  <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_done) begin
                        if (out_free) begin
                            o_last_reg <= 1'b1;
                            if (pend_valid_reg) begin
                                o_status_reg <= ST_FIRED;
                                o_id_reg     <= pend_id_reg;
                                o_missed_reg <= pend_missed_reg;
                            end else begin
                                o_status_reg <= ST_IDLE;
                                o_id_reg     <= 8'd0;
                                o_missed_reg <= missed_reg;
                            end
                            pend_valid_reg <= 1'b0;
                            count_reg      <= len_reg;
                            state_reg      <= S_IDLE;
                        end
                    end else if (due_now && late) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (!div_busy) begin
                        missed_reg <= missed_reg + div_q;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (walk_step) begin
                        if (report) begin
                            if (pend_valid_reg) begin
                                o_status_reg <= ST_FIRED;
                                o_id_reg     <= pend_id_reg;
                                o_last_reg   <= 1'b0;
                                o_missed_reg <= pend_missed_reg;
                            end
                            pend_valid_reg  <= 1'b1;
                            pend_id_reg     <= head.id;
                            pend_missed_reg <= missed_reg;
                            nres_reg        <= nres_reg + RW'(1);
                        end
                        if (!walk_keep) len_reg <= len_reg - CW'(1);
                        step_reg  <= step_reg + CW'(1);
                        state_reg <= S_WALK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'd0, o_missed_reg, o_id_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

    `DTS_ASSERT(a_count_max, aclk, aresetn, count_reg <= CW'(MAX_TASKS), "count overflow")
    `DTS_ASSERT(a_div_state, aclk, aresetn, div_busy |-> state_reg == S_DIV, "divider idle misuse")
    `DTS_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "beat dropped")
endmodule

// ===== rtl/dts_cell.sv =====
// one table slot of the rotating slot chain
// depends on dts_pkg and the macros header
`timescale 1ns / 1ps
`include "deadline_task_scheduler_core_macros.svh"
module dts_cell
    import dts_pkg::*;
(
    input  logic  aclk,
    input  logic  shift_en,
    input  slot_t slot_in,
    output slot_t slot_out
);
    slot_t slot_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            slot_reg <= slot_in;
        end
    end

    assign slot_out = slot_reg;

    `DTS_ASSERT_NORST(a_cell_hold, aclk, !shift_en |=> slot_reg === $past(slot_reg), "cell changed")
endmodule

// ===== rtl/dts_div.sv =====
// 32-bit restoring divider, one quotient bit per cycle
// depends on no other file
`timescale 1ns / 1ps
module dts_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [31:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, q_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= 6'd32;
        end else if (cnt_reg != 6'd0) begin
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
                q_reg   <= {q_reg[30:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], q_reg[31]};
                q_reg   <= {q_reg[30:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = q_reg;
endmodule

// ===== sim/testbench.sv =====
// self-checking bench for deadline_task_scheduler_core: directed table then random adds/ticks
// depends on dts_pkg and the scheduler rtl; holds its own model of the task table
`timescale 1ns / 1ps
module testbench;
    import dts_pkg::*;

    localparam int TASKS = 16;
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        kind;
        logic [31:0] now;
        logic [7:0]  id;
        logic [31:0] delay;
        logic        rep;
    } beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  id;
        logic        last;
        logic [31:0] missed;
    } res_t;

    typedef struct {
        beat_t b;
        bit    has_exp;
        res_t  r;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    deadline_task_scheduler_core dut (.*);

    always #4 aclk = ~aclk;

    // model state
    logic [7:0]  tbl_id [TASKS];
    logic [31:0] tbl_due [TASKS];
    logic [31:0] tbl_iv [TASKS];
    logic        tbl_rep [TASKS];
    int          tbl_n = 0;
    logic [31:0] missed_sum = '0;

    res_t pending_results[$];
    row_t rows[$];
    int   errors = 0;
    int   cycles = 0;
    bit   hold_off = 0;
    logic [31:0] clock_ms = '0;

    task automatic add_expected(input res_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic add_row(input row_t x);
        rows.insert(rows.size(), x);
    endtask

    task automatic schedule(input beat_t b);
        int k, w;
        logic keep;
        res_t r;
        k = 0;
        w = 0;
        if (b.kind == KIND_ADD) begin
            r.id = b.id;
            r.last = 1'b1;
            r.missed = missed_sum;
            if (tbl_n >= TASKS) begin
                r.status = ST_REJECTED;
            end else begin
                tbl_id[tbl_n] = b.id;
                tbl_due[tbl_n] = b.now + b.delay;
                tbl_iv[tbl_n] = b.delay;
                tbl_rep[tbl_n] = b.rep;
                tbl_n++;
                r.status = ST_ADDED;
            end
            add_expected(r);
            return;
        end
        for (int i = 0; i < tbl_n; i++) begin
            keep = 1'b1;
            if (b.now >= tbl_due[i]) begin
                if (tbl_rep[i]) begin
                    if (tbl_iv[i] != 0 && b.now > tbl_due[i] + tbl_iv[i])
                        missed_sum = missed_sum + (b.now - tbl_due[i]) / tbl_iv[i];
                    tbl_due[i] = b.now + tbl_iv[i];
                end else begin
                    keep = 1'b0;
                end
                if (k < MAX_RESULTS) begin
                    r.status = ST_FIRED;
                    r.id = tbl_id[i];
                    r.last = 1'b0;
                    r.missed = missed_sum;
                    add_expected(r);
                    k++;
                end
            end
            if (keep) begin
                tbl_id[w] = tbl_id[i];
                tbl_due[w] = tbl_due[i];
                tbl_iv[w] = tbl_iv[i];
                tbl_rep[w] = tbl_rep[i];
                w++;
            end
        end
        tbl_n = w;
        if (k == 0) begin
            r.status = ST_IDLE;
            r.id = '0;
            r.last = 1'b1;
            r.missed = missed_sum;
            add_expected(r);
        end else begin
            pending_results[$].last = 1'b1;
        end
    endtask

    task automatic send(input beat_t b);
        int idle;
        idle = $urandom_range(0, 13);
        @(negedge aclk);
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_tdata <= {7'd0, b.rep, b.delay, b.id, b.now};
        s_tuser <= b.kind;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        schedule(b);
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic beat_t mk(logic kind, logic [31:0] now, logic [7:0] id,
                                 logic [31:0] delay, logic rep);
        beat_t b;
        b.kind = kind;
        b.now = now;
        b.id = id;
        b.delay = delay;
        b.rep = rep;
        return b;
    endfunction

    function automatic beat_t rand_beat();
        beat_t b;
        b.kind = ($urandom_range(0, 99) < 45) ? KIND_ADD : KIND_TICK;
        b.id = 8'($urandom);
        b.rep = 1'($urandom);
        case ($urandom_range(0, 3))
            0: b.delay = $urandom_range(0, 3);
            1: b.delay = $urandom_range(1, 40);
            2: b.delay = $urandom_range(100, 1000);
            default: b.delay = $urandom;
        endcase
        if ($urandom_range(0, 19) == 0) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 300);
        end
        b.now = clock_ms;
        if (b.kind == KIND_TICK) begin
            b.id = 8'($urandom);
            b.delay = $urandom;
        end
        return b;
    endfunction

    // receiver
    always @(posedge aclk) begin
        res_t got, want;
        if (m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.id = m_tdata[9:2];
            got.missed = m_tdata[41:10];
            got.last = m_tlast;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat status=%0d id=%0d", got.status, got.id);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.id !== want.id) begin
                    $error("fired_id expected %0d actual %0d", want.id, got.id);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, got.last);
                    errors++;
                end
                if (got.missed !== want.missed) begin
                    $error("missed_runs expected %0d actual %0d", want.missed, got.missed);
                    errors++;
                end
            end
        end
    end

    initial begin
        int wait_n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                if (wait_n != 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(negedge aclk);
                end
                if (!hold_off) begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                    while (!(m_tvalid && m_tready) && !hold_off) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic row_t rw(beat_t b, bit has, logic [1:0] st, logic [7:0] id,
                                logic last, logic [31:0] ms);
        row_t x;
        x.b = b;
        x.has_exp = has;
        x.r.status = st;
        x.r.id = id;
        x.r.last = last;
        x.r.missed = ms;
        return x;
    endfunction

    initial begin
        res_t tmp;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty tick, extremes, zero-interval repeat, late repeat, full table
        add_row(rw(mk(KIND_TICK, 32'hFFFF_FFFF, 8'hFF, '1, 1'b1), 1'b1,
                   ST_IDLE, 8'h00, 1'b1, 32'd0));
        add_row(rw(mk(KIND_ADD, 32'd0, 8'h00, 32'd0, 1'b1), 1'b1,
                   ST_ADDED, 8'h00, 1'b1, 32'd0));
        add_row(rw(mk(KIND_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0), 1'b1,
                   ST_ADDED, 8'hFF, 1'b1, 32'd0));
        add_row(rw(mk(KIND_ADD, 32'd10, 8'h55, 32'd10, 1'b1), 1'b1,
                   ST_ADDED, 8'h55, 1'b1, 32'd0));
        add_row(rw(mk(KIND_ADD, 32'd10, 8'hAA, 32'd5, 1'b0), 1'b0,
                   ST_ADDED, 8'h00, 1'b0, 32'd0));
        add_row(rw(mk(KIND_TICK, 32'd5, 8'h12, 32'd7, 1'b0), 1'b0,
                   ST_ADDED, 8'h00, 1'b0, 32'd0));
        add_row(rw(mk(KIND_TICK, 32'd100, 8'h00, 32'd0, 1'b0), 1'b0,
                   ST_ADDED, 8'h00, 1'b0, 32'd0));
        add_row(rw(mk(KIND_TICK, 32'hFFFF_FFF0, 8'h00, 32'd0, 1'b1), 1'b0,
                   ST_ADDED, 8'h00, 1'b0, 32'd0));
        for (int i = 0; i < 15; i++)
            add_row(rw(mk(KIND_ADD, 32'h8000_0000, i[7:0] + 8'h10, 32'hFFFF, i[0]),
                       1'b0, ST_ADDED, 8'h00, 1'b0, 32'd0));
        add_row(rw(mk(KIND_ADD, 32'd0, 8'hEE, 32'd1, 1'b1), 1'b0,
                   ST_ADDED, 8'h00, 1'b0, 32'd0));
        add_row(rw(mk(KIND_TICK, 32'hFFFF_FFFF, 8'h00, 32'd0, 1'b0), 1'b0,
                   ST_ADDED, 8'h00, 1'b0, 32'd0));

        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                send(rows[i].b);
                tmp = pending_results[$];
                if (tmp !== rows[i].r) begin
                    $error("table row %0d expected %h model %h", i, rows[i].r, tmp);
                    errors++;
                end
            end else begin
                send(rows[i].b);
            end
        end

        // let the receiver hold off while beats keep coming
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 20; i++) send(rand_beat());
            end
        join

        // sender pauses until everything is drained
        sender_idle();
        while (pending_results.size() != 0) @(posedge aclk);

        for (int i = 0; i < 135; i++) send(rand_beat());

        sender_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
